[src/plc_pkg.sv]
package plc_pkg;

    localparam int COORD_WIDTH_DEF = 16;
    localparam int S_TDATA_W       = 72;
    localparam int S_TUSER_W       = 3;
    localparam int M_TDATA_W       = 40;

    // item kinds carried in the mode field
    localparam logic [2:0] MODE_TICK   = 3'd0;
    localparam logic [2:0] MODE_LINE   = 3'd1;
    localparam logic [2:0] MODE_ABS    = 3'd2;
    localparam logic [2:0] MODE_REL    = 3'd3;
    localparam logic [2:0] MODE_HOME   = 3'd4;
    localparam logic [2:0] MODE_CIRCLE = 3'd5;

    // line pen requests
    localparam logic [1:0] PEN_RAISE = 2'd0;
    localparam logic [1:0] PEN_LOWER = 2'd1;

    // motor step codes
    localparam logic [3:0] CODE_NONE = 4'h0;
    localparam logic [3:0] CODE_YP   = 4'h3;
    localparam logic [3:0] CODE_YN   = 4'h2;
    localparam logic [3:0] CODE_XP   = 4'hC;
    localparam logic [3:0] CODE_XN   = 4'h8;
    localparam logic [3:0] CODE_DIAG = CODE_XN | CODE_YN;

    typedef enum logic [5:0] {
        ACT_IDLE      = 6'b000001,
        ACT_LINE      = 6'b000010,
        ACT_CIRCLE    = 6'b000100,
        ACT_HOME_DIAG = 6'b001000,
        ACT_HOME_TOP  = 6'b010000,
        ACT_HOME_LEFT = 6'b100000
    } act_t;

    typedef struct packed {
        logic [2:0]         mode;
        logic signed [15:0] target_x;
        logic signed [15:0] target_y;
        logic [1:0]         pen_request;
        logic signed [15:0] centre_offset_x;
        logic signed [15:0] centre_offset_y;
        logic               left_limit_hit;
        logic               top_limit_hit;
    } item_t;

    typedef struct packed {
        logic [3:0]         motor_code;
        logic               pen_down;
        logic               busy_res;
        logic signed [15:0] position_x;
        logic signed [15:0] position_y;
        logic               rejected;
    } res_t;

endpackage

[src/plotter_line_circle_stepper.sv]
// Two-axis plotter step generator: Bresenham lines, midpoint circles and homing.
//
// Input channel (s_): one item per handshake. s_tuser carries the mode (tick or
// one of the commands line, absolute, relative, home, circle); s_tdata carries
// targets, pen request, circle centre offsets and the two end switches.
// Result channel (m_): exactly one item per input item, in order, with the step
// code for this tick, pen state, busy flag, position and the rejected flag.
//
// The item is first held in the input register, then its result is computed and
// captured in the result register, which drives m_tvalid. Throughput: one item per
// cycle while the result channel is not stalled; each item reads the state that the
// previous one left.
//
// Reset (aresetn low, synchronous): both channels empty, position and move state
// cleared, circle quadrant set to 1, pen raised, absolute mode, no move active.
// Stall: while m_tready is low the result register holds its item; one more item
// waits in the input register, after which s_tready drops.
module plotter_line_circle_stepper
    import plc_pkg::*;
#(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // low bit up: target_x[15:0], target_y[31:16], pen_request[33:32],
    // centre_offset_x[49:34], centre_offset_y[65:50], left_limit_hit[66],
    // top_limit_hit[67], zero pad[71:68]
    input  logic [S_TDATA_W-1:0] s_tdata,
    // mode[2:0]
    input  logic [S_TUSER_W-1:0] s_tuser,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // low bit up: motor_code[3:0], pen_down[4], busy_res[5], position_x[21:6],
    // position_y[37:22], rejected[38], zero pad[39]
    output logic [M_TDATA_W-1:0] m_tdata
);

    item_t s_item;
    item_t item;
    logic  item_valid;
    logic  out_space;
    logic  fire;
    res_t  core_res;
    res_t  m_res;

    // unpack the input item
    assign s_item.mode            = s_tuser;
    assign s_item.target_x        = s_tdata[15:0];
    assign s_item.target_y        = s_tdata[31:16];
    assign s_item.pen_request     = s_tdata[33:32];
    assign s_item.centre_offset_x = s_tdata[49:34];
    assign s_item.centre_offset_y = s_tdata[65:50];
    assign s_item.left_limit_hit  = s_tdata[66];
    assign s_item.top_limit_hit   = s_tdata[67];

    // advance the held item whenever the result register can take its result
    assign fire = item_valid && out_space;

    plc_in_stage u_in_stage (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_tvalid),
        .s_ready    (s_tready),
        .s_item     (s_item),
        .advance    (fire),
        .item_valid (item_valid),
        .item       (item)
    );

    plc_core #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .fire    (fire),
        .item    (item),
        .res     (core_res)
    );

    plc_out_stage u_out_stage (
        .aclk    (aclk),
        .aresetn (aresetn),
        .load    (fire),
        .res_in  (core_res),
        .space   (out_space),
        .m_valid (m_tvalid),
        .m_ready (m_tready),
        .m_res   (m_res)
    );

    // pack the result item
    assign m_tdata = {1'b0, m_res.rejected, m_res.position_y, m_res.position_x,
                      m_res.busy_res, m_res.pen_down, m_res.motor_code};

endmodule

[src/plc_in_stage.sv]
module plc_in_stage
    import plc_pkg::*;
(
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  s_valid,
    output logic  s_ready,
    input  item_t s_item,
    input  logic  advance,
    output logic  item_valid,
    output item_t item
);

    logic  valid_reg;
    logic  valid_next;
    item_t item_reg;

    assign s_ready    = !valid_reg || advance;
    assign item_valid = valid_reg;
    assign item       = item_reg;

    always_comb begin
        valid_next = valid_reg;
        if (s_valid && s_ready) begin
            valid_next = 1'b1;
        end else if (advance) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    // payload: hold unless a new item is taken
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            item_reg <= s_item;
        end
    end

endmodule

[src/plc_core.sv]
module plc_core
    import plc_pkg::*;
#(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  fire,
    input  item_t item,
    output res_t  res
);

    localparam int W  = COORD_WIDTH;
    localparam int DW = COORD_WIDTH + 2;
    localparam int EW = COORD_WIDTH + 4;

    typedef logic signed [W-1:0]  coord_t;
    typedef logic signed [DW-1:0] delta_t;
    typedef logic signed [EW-1:0] err_t;

    // architectural state
    coord_t         pos_x_reg, pos_y_reg, wp_x_reg, wp_y_reg;
    coord_t         end_x_reg, end_y_reg, ctr_x_reg, ctr_y_reg;
    delta_t         dlt_x_reg, dlt_y_reg;
    err_t           err_reg;
    logic           neg_x_reg, neg_y_reg;
    logic [W-1:0]   radius_reg;
    logic [2:0]     quad_reg;
    logic           rel_reg, pen_raised_reg;
    act_t           act_reg;

    // state after the command or step, before the waypoint update
    coord_t         pre_px, pre_py, pre_wx, pre_wy, pre_ex, pre_ey, pre_cx, pre_cy;
    delta_t         pre_dx, pre_dy;
    err_t           pre_err;
    logic           pre_nx, pre_ny;
    logic [W-1:0]   pre_radius;
    logic [2:0]     pre_quad;
    logic           pre_rel, pre_pen;
    act_t           pre_act;
    logic           do_arr;
    logic [3:0]     code;
    logic           rej;

    // command-side helpers
    coord_t         step_dx, step_dy, in_tx, in_ty, in_cx, in_cy;
    logic signed [W:0] ln_dx, ln_dy;
    logic [W:0]     ln_mx, ln_my;

    // waypoint update
    coord_t         nxt_wx, nxt_wy;
    delta_t         nxt_dx, nxt_dy;
    err_t           nxt_err;
    logic [2:0]     nxt_quad;
    act_t           nxt_act;
    logic signed [EW:0] l_e2;
    err_t           l_err1;
    delta_t         c_dx1, c_dy1, rst_dx;
    err_t           c_err1, c_err2, rst_err;
    logic [2:0]     c_quad;

    function automatic coord_t wp_x_f(input logic [2:0] q, input delta_t x, input delta_t y,
                                      input coord_t c);
        delta_t ce;
        ce = DW'(c);
        case (q)
            3'd1:    wp_x_f = W'(ce - x);
            3'd2:    wp_x_f = W'(ce - y);
            3'd3:    wp_x_f = W'(ce + x);
            default: wp_x_f = W'(ce + y);
        endcase
    endfunction

    function automatic coord_t wp_y_f(input logic [2:0] q, input delta_t x, input delta_t y,
                                      input coord_t c);
        delta_t ce;
        ce = DW'(c);
        case (q)
            3'd1:    wp_y_f = W'(ce + y);
            3'd2:    wp_y_f = W'(ce - x);
            3'd3:    wp_y_f = W'(ce - y);
            default: wp_y_f = W'(ce + x);
        endcase
    endfunction

    assign in_tx   = W'(item.target_x);
    assign in_ty   = W'(item.target_y);
    assign in_cx   = W'(item.centre_offset_x);
    assign in_cy   = W'(item.centre_offset_y);
    assign step_dx = wp_x_reg - pos_x_reg;
    assign step_dy = wp_y_reg - pos_y_reg;

    // line deltas: relative target is the delta itself, absolute needs one extra bit
    assign ln_dx = rel_reg ? (W+1)'(in_tx) : (W+1)'(in_tx) - (W+1)'(pos_x_reg);
    assign ln_dy = rel_reg ? (W+1)'(in_ty) : (W+1)'(in_ty) - (W+1)'(pos_y_reg);
    assign ln_mx = ln_dx[W] ? -ln_dx : ln_dx;
    assign ln_my = ln_dy[W] ? -ln_dy : ln_dy;

    always_comb begin
        pre_px     = pos_x_reg;
        pre_py     = pos_y_reg;
        pre_wx     = wp_x_reg;
        pre_wy     = wp_y_reg;
        pre_ex     = end_x_reg;
        pre_ey     = end_y_reg;
        pre_cx     = ctr_x_reg;
        pre_cy     = ctr_y_reg;
        pre_dx     = dlt_x_reg;
        pre_dy     = dlt_y_reg;
        pre_err    = err_reg;
        pre_nx     = neg_x_reg;
        pre_ny     = neg_y_reg;
        pre_radius = radius_reg;
        pre_quad   = quad_reg;
        pre_rel    = rel_reg;
        pre_pen    = pen_raised_reg;
        pre_act    = act_reg;
        do_arr     = 1'b0;
        code       = CODE_NONE;
        rej        = 1'b0;
        if (item.mode == MODE_TICK) begin
            if (act_reg == ACT_LINE || act_reg == ACT_CIRCLE) begin
                // x first, then y, one step toward the waypoint
                if (pos_x_reg != wp_x_reg) begin
                    if (step_dx[W-1]) begin
                        pre_px = pos_x_reg - W'(1);
                        code   = CODE_XN;
                    end else begin
                        pre_px = pos_x_reg + W'(1);
                        code   = CODE_XP;
                    end
                end else if (pos_y_reg != wp_y_reg) begin
                    if (step_dy[W-1]) begin
                        pre_py = pos_y_reg - W'(1);
                        code   = CODE_YN;
                    end else begin
                        pre_py = pos_y_reg + W'(1);
                        code   = CODE_YP;
                    end
                end
                do_arr = (pre_px == wp_x_reg) && (pre_py == wp_y_reg);
            end else if (act_reg inside {ACT_HOME_DIAG, ACT_HOME_TOP, ACT_HOME_LEFT}) begin
                if (act_reg == ACT_HOME_DIAG && !item.left_limit_hit
                        && !item.top_limit_hit) begin
                    code = CODE_DIAG;
                end else if ((act_reg == ACT_HOME_DIAG || act_reg == ACT_HOME_TOP)
                        && !item.top_limit_hit) begin
                    code    = CODE_YN;
                    pre_act = ACT_HOME_TOP;
                end else if (!item.left_limit_hit) begin
                    code    = CODE_XN;
                    pre_act = ACT_HOME_LEFT;
                end else begin
                    pre_px  = '0;
                    pre_py  = '0;
                    pre_act = ACT_IDLE;
                end
            end
        end else if (item.mode inside {[MODE_LINE:MODE_CIRCLE]}) begin
            if (act_reg != ACT_IDLE) begin
                rej = 1'b1;
            end else begin
                case (item.mode)
                    MODE_LINE: begin
                        if (item.pen_request == PEN_LOWER) pre_pen = 1'b0;
                        if (item.pen_request == PEN_RAISE) pre_pen = 1'b1;
                        pre_ex  = rel_reg ? pos_x_reg + in_tx : in_tx;
                        pre_ey  = rel_reg ? pos_y_reg + in_ty : in_ty;
                        pre_nx  = ln_dx[W];
                        pre_ny  = ln_dy[W];
                        pre_dx  = DW'(ln_mx);
                        pre_dy  = DW'(0) - DW'(ln_my);
                        pre_err = EW'(ln_mx) - EW'(ln_my);
                        pre_wx  = pos_x_reg;
                        pre_wy  = pos_y_reg;
                        pre_act = ACT_LINE;
                        do_arr  = 1'b1;
                    end
                    MODE_ABS: pre_rel = 1'b0;
                    MODE_REL: pre_rel = 1'b1;
                    MODE_HOME: begin
                        pre_pen = 1'b1;
                        pre_act = ACT_HOME_DIAG;
                    end
                    default: begin
                        pre_radius = in_cx[W-1] ? -in_cx : in_cx;
                        pre_cx     = pos_x_reg + in_cx;
                        pre_cy     = pos_y_reg + in_cy;
                        pre_dx     = DW'(0) - DW'(pre_radius);
                        pre_dy     = '0;
                        pre_err    = EW'(2) - EW'({pre_radius, 1'b0});
                        pre_quad   = 3'd1;
                        pre_wx     = wp_x_f(3'd1, pre_dx, pre_dy, pre_cx);
                        pre_wy     = wp_y_f(3'd1, pre_dx, pre_dy, pre_cy);
                        pre_act    = ACT_CIRCLE;
                        do_arr     = (pos_x_reg == pre_wx) && (pos_y_reg == pre_wy);
                    end
                endcase
            end
        end
    end

    // Bresenham advance terms
    assign l_e2   = {pre_err, 1'b0};
    assign l_err1 = (l_e2 >= (EW+1)'(pre_dy)) ? pre_err + EW'(pre_dy) : pre_err;

    // midpoint circle terms
    assign c_dy1   = (pre_err <= EW'(pre_dy)) ? pre_dy + DW'(1) : pre_dy;
    assign c_err1  = (pre_err <= EW'(pre_dy)) ? pre_err + err_t'({EW'(c_dy1), 1'b1})
                                              : pre_err;
    assign c_dx1   = (pre_err > EW'(pre_dx) || c_err1 > EW'(c_dy1)) ? pre_dx + DW'(1)
                                                                    : pre_dx;
    assign c_err2  = (pre_err > EW'(pre_dx) || c_err1 > EW'(c_dy1))
                   ? c_err1 + err_t'({EW'(c_dx1), 1'b1}) : c_err1;
    assign rst_dx  = DW'(0) - DW'(pre_radius);
    assign rst_err = EW'(2) - EW'({pre_radius, 1'b0});
    assign c_quad  = c_dx1[DW-1] ? pre_quad : pre_quad + 3'd1;

    always_comb begin
        nxt_wx   = pre_wx;
        nxt_wy   = pre_wy;
        nxt_dx   = pre_dx;
        nxt_dy   = pre_dy;
        nxt_err  = pre_err;
        nxt_quad = pre_quad;
        nxt_act  = pre_act;
        if (do_arr && pre_act == ACT_LINE) begin
            // position sits on the waypoint, so the end check uses the waypoint
            if (pre_wx == pre_ex && pre_wy == pre_ey) begin
                nxt_act = ACT_IDLE;
            end else begin
                nxt_err = l_err1;
                if (l_e2 >= (EW+1)'(pre_dy)) begin
                    nxt_wx = pre_nx ? pre_wx - W'(1) : pre_wx + W'(1);
                end
                if (l_e2 <= (EW+1)'(pre_dx)) begin
                    nxt_err = l_err1 + EW'(pre_dx);
                    nxt_wy  = pre_ny ? pre_wy - W'(1) : pre_wy + W'(1);
                end
            end
        end else if (do_arr && pre_act == ACT_CIRCLE) begin
            nxt_quad = c_quad;
            if (!c_dx1[DW-1]) begin
                nxt_dx  = rst_dx;
                nxt_dy  = '0;
                nxt_err = rst_err;
            end else begin
                nxt_dx  = c_dx1;
                nxt_dy  = c_dy1;
                nxt_err = c_err2;
            end
            if (c_quad >= 3'd5) begin
                nxt_act = ACT_IDLE;
            end else begin
                nxt_wx = wp_x_f(c_quad, nxt_dx, nxt_dy, pre_cx);
                nxt_wy = wp_y_f(c_quad, nxt_dx, nxt_dy, pre_cy);
            end
        end
    end

    assign res.motor_code = code;
    assign res.pen_down   = !pre_pen;
    assign res.busy_res   = (nxt_act != ACT_IDLE);
    assign res.position_x = 16'(pre_px);
    assign res.position_y = 16'(pre_py);
    assign res.rejected   = rej;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_x_reg      <= '0;
            pos_y_reg      <= '0;
            wp_x_reg       <= '0;
            wp_y_reg       <= '0;
            end_x_reg      <= '0;
            end_y_reg      <= '0;
            ctr_x_reg      <= '0;
            ctr_y_reg      <= '0;
            dlt_x_reg      <= '0;
            dlt_y_reg      <= '0;
            err_reg        <= '0;
            neg_x_reg      <= 1'b0;
            neg_y_reg      <= 1'b0;
            radius_reg     <= '0;
            quad_reg       <= 3'd1;
            rel_reg        <= 1'b0;
            pen_raised_reg <= 1'b1;
            act_reg        <= ACT_IDLE;
        end else if (fire) begin
            pos_x_reg      <= pre_px;
            pos_y_reg      <= pre_py;
            wp_x_reg       <= nxt_wx;
            wp_y_reg       <= nxt_wy;
            end_x_reg      <= pre_ex;
            end_y_reg      <= pre_ey;
            ctr_x_reg      <= pre_cx;
            ctr_y_reg      <= pre_cy;
            dlt_x_reg      <= nxt_dx;
            dlt_y_reg      <= nxt_dy;
            err_reg        <= nxt_err;
            neg_x_reg      <= pre_nx;
            neg_y_reg      <= pre_ny;
            radius_reg     <= pre_radius;
            quad_reg       <= nxt_quad;
            rel_reg        <= pre_rel;
            pen_raised_reg <= pre_pen;
            act_reg        <= nxt_act;
        end
    end

    a_rej_keeps_pos: assert property (@(posedge aclk) disable iff (!aresetn)
        fire && rej |=> pos_x_reg == $past(pos_x_reg) && pos_y_reg == $past(pos_y_reg))
        else $error("rejected command moved the position");

    a_cmd_no_step: assert property (@(posedge aclk) disable iff (!aresetn)
        fire && item.mode != MODE_TICK |-> code == CODE_NONE)
        else $error("command item produced a step code");

    a_home_pen_up: assert property (@(posedge aclk) disable iff (!aresetn)
        fire && act_reg == ACT_IDLE && item.mode == MODE_HOME |=> pen_raised_reg)
        else $error("homing started with the pen down");

    a_quad_range: assert property (@(posedge aclk) disable iff (!aresetn)
        quad_reg >= 3'd1 && quad_reg <= 3'd5)
        else $error("circle quadrant out of range");

    a_idle_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        !fire |=> $stable(pos_x_reg) && $stable(pos_y_reg) && $stable(act_reg))
        else $error("state changed without an item");

endmodule

[src/plc_out_stage.sv]
module plc_out_stage
    import plc_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    input  logic load,
    input  res_t res_in,
    output logic space,
    output logic m_valid,
    input  logic m_ready,
    output res_t m_res
);

    logic valid_reg;
    logic valid_next;
    res_t res_reg;

    assign space   = !valid_reg || m_ready;
    assign m_valid = valid_reg;
    assign m_res   = res_reg;

    always_comb begin
        valid_next = valid_reg;
        if (load) begin
            valid_next = 1'b1;
        end else if (m_ready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            res_reg <= res_in;
        end
    end

endmodule
